// File: design/srb_pkg.sv
package srb_pkg;

  localparam int unsigned RING_DEPTH = 32;

  localparam logic [31:0] MAX_DIFF_RST = 32'd100;
  localparam logic [15:0] LOST_TO_RST  = 16'd200;
  localparam logic [15:0] GAP_MAX      = 16'hFFFF;
  localparam logic [31:0] SEQ_MAX      = 32'hFFFF_FFFF;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_TO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK     = 2'd2;

  typedef enum logic [1:0] {
    ACT_PACKET = 2'd0,
    ACT_DRAIN  = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_FORCE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RESYNC = 2'd1,
    ST_REJECT = 2'd2,
    ST_WAIT   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    clr_wr;
    logic    load_item;
    logic    arr_dist;
    logic    arr_wr0;
    logic    arr_wr1;
    logic    tick;
    logic    force_upd;
    logic    rd_slot;
    logic    latch_tag;
    logic    deliver;
    logic    sk_start;
    logic    sk_step;
    logic    sk_lim;
    logic    sk_mul1;
    logic    sk_mul2;
    logic    sk_mul3;
    logic    sk_apply;
    logic    gap_start;
    logic    nn_rd;
    logic    nn_adv;
    logic    nn_take;
    logic    nn_end;
    logic    emit_pkt;
    logic    emit_close;
    status_e close_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    clear_last;
    action_e action;
    logic    packet_ok;
    logic    empty_start;
    logic    rp_lt_wp;
    logic    tag_match;
    logic    tag_gt;
    logic    expired;
    logic    skip_ok;
    logic    resync;
    logic    nn_more;
    logic    nn_hit;
    logic    emit_ok;
    logic    out_busy;
    logic    scan_last;
  } sts_t;

endpackage

// File: design/srb_ctrl.sv
module srb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  srb_pkg::sts_t sts_i,
  output srb_pkg::cmd_t cmd_o
);

  typedef enum logic [21:0] {
    S_CLEAR    = 22'b0000000000000000000001,
    S_IDLE     = 22'b0000000000000000000010,
    S_DISP     = 22'b0000000000000000000100,
    S_ARR_CMP  = 22'b0000000000000000001000,
    S_ARR_WR0  = 22'b0000000000000000010000,
    S_ARR_WR1  = 22'b0000000000000000100000,
    S_DR_CHECK = 22'b0000000000000001000000,
    S_DR_EVAL  = 22'b0000000000000010000000,
    S_DR_EMIT  = 22'b0000000000000100000000,
    S_SK_SCAN  = 22'b0000000000001000000000,
    S_SK_LAST  = 22'b0000000000010000000000,
    S_SK_LIM   = 22'b0000000000100000000000,
    S_SK_MUL1  = 22'b0000000001000000000000,
    S_SK_MUL2  = 22'b0000000010000000000000,
    S_SK_MUL3  = 22'b0000000100000000000000,
    S_SK_APPLY = 22'b0000001000000000000000,
    S_GAP      = 22'b0000010000000000000000,
    S_NN_CHECK = 22'b0000100000000000000000,
    S_NN_EVAL  = 22'b0001000000000000000000,
    S_DONE     = 22'b0010000000000000000000,
    S_SPARE0   = 22'b0100000000000000000000,
    S_SPARE1   = 22'b1000000000000000000000
  } state_e;

  state_e state_q, state_d;
  srb_pkg::status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= srb_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.close_status = st_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        st_d = srb_pkg::ST_OK;
        unique case (sts_i.action)
          srb_pkg::ACT_PACKET: begin
            if (!sts_i.packet_ok) begin
              st_d    = srb_pkg::ST_REJECT;
              state_d = S_DONE;
            end else begin
              state_d = S_ARR_CMP;
            end
          end
          srb_pkg::ACT_DRAIN: begin
            state_d = sts_i.empty_start ? S_DONE : S_DR_CHECK;
          end
          srb_pkg::ACT_TICK: begin
            cmd_o.tick = 1'b1;
            state_d = S_DONE;
          end
          srb_pkg::ACT_FORCE: begin
            cmd_o.force_upd = 1'b1;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ARR_CMP: begin
        cmd_o.arr_dist = 1'b1;
        state_d = S_ARR_WR0;
      end
      S_ARR_WR0: begin
        cmd_o.arr_wr0 = 1'b1;
        state_d = S_ARR_WR1;
      end
      S_ARR_WR1: begin
        cmd_o.arr_wr1 = 1'b1;
        st_d = sts_i.resync ? srb_pkg::ST_RESYNC : srb_pkg::ST_OK;
        state_d = S_DONE;
      end
      S_DR_CHECK: begin
        if (sts_i.rp_lt_wp) begin
          cmd_o.rd_slot = 1'b1;
          state_d = S_DR_EVAL;
        end else begin
          st_d    = srb_pkg::ST_OK;
          state_d = S_DONE;
        end
      end
      S_DR_EVAL: begin
        cmd_o.latch_tag = 1'b1;
        if (sts_i.tag_match) begin
          cmd_o.deliver = 1'b1;
          state_d = sts_i.emit_ok ? S_DR_EMIT : S_DR_CHECK;
        end else if (!sts_i.expired) begin
          st_d    = srb_pkg::ST_WAIT;
          state_d = S_DONE;
        end else if (sts_i.tag_gt) begin
          cmd_o.sk_start = 1'b1;
          state_d = S_SK_SCAN;
        end else begin
          state_d = S_GAP;
        end
      end
      S_DR_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_pkt = 1'b1;
          state_d = S_DR_CHECK;
        end
      end
      S_SK_SCAN: begin
        cmd_o.sk_step = 1'b1;
        if (sts_i.scan_last) state_d = S_SK_LAST;
      end
      S_SK_LAST: state_d = S_SK_LIM;
      S_SK_LIM: begin
        cmd_o.sk_lim = 1'b1;
        state_d = S_SK_MUL1;
      end
      S_SK_MUL1: begin
        if (sts_i.skip_ok) begin
          cmd_o.sk_mul1 = 1'b1;
          state_d = S_SK_MUL2;
        end else begin
          state_d = S_GAP;
        end
      end
      S_SK_MUL2: begin
        cmd_o.sk_mul2 = 1'b1;
        state_d = S_SK_MUL3;
      end
      S_SK_MUL3: begin
        cmd_o.sk_mul3 = 1'b1;
        state_d = S_SK_APPLY;
      end
      S_SK_APPLY: begin
        cmd_o.sk_apply = 1'b1;
        state_d = S_DR_CHECK;
      end
      S_GAP: begin
        cmd_o.gap_start = 1'b1;
        state_d = S_NN_CHECK;
      end
      S_NN_CHECK: begin
        if (sts_i.nn_more) begin
          cmd_o.nn_rd = 1'b1;
          state_d = S_NN_EVAL;
        end else begin
          cmd_o.nn_end = 1'b1;
          state_d = S_DR_CHECK;
        end
      end
      S_NN_EVAL: begin
        if (sts_i.nn_hit) begin
          cmd_o.nn_take = 1'b1;
          state_d = S_DR_CHECK;
        end else begin
          cmd_o.nn_adv = 1'b1;
          state_d = S_NN_CHECK;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_close = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

// File: design/srb_dp.sv
module srb_dp #(
  parameter int unsigned RING_DEPTH = srb_pkg::RING_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srb_pkg::cmd_t                  cmd_i,
  output srb_pkg::sts_t                  sts_o,
  input  logic                           cfg_we_i,
  input  logic [srb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic [1:0]                     in_action_i,
  input  logic [31:0]                    in_seq_i,
  input  logic                           in_ok_i,
  input  logic [63:0]                    in_payload_i,
  input  logic                           m_tready_i,
  output logic                           out_valid_o,
  output logic                           out_kind_o,
  output logic [31:0]                    out_seq_o,
  output logic [63:0]                    out_payload_o,
  output logic [1:0]                     out_status_o,
  output logic [31:0]                    out_lost_o,
  output logic                           out_last_o
);

  // ring depth must be a power of two: slot index is the low bits
  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(RING_DEPTH + 1);

  logic [31:0] slot_seq_mem  [RING_DEPTH];
  logic [63:0] slot_data_mem [RING_DEPTH];

  logic [31:0] max_diff_q;
  logic [15:0] lost_to_q;
  logic        lock_q;

  logic [31:0] read_ptr_q, write_ptr_q, lost_q;
  logic [15:0] gap_q;
  logic [AW-1:0] clr_q;

  logic [1:0]  it_action_q;
  logic [31:0] it_seq_q;
  logic        it_ok_q;
  logic [63:0] it_pay_q;

  logic        far_q, full_q;
  logic [31:0] seq_rd_q, cur_tag_q;
  logic [63:0] data_rd_q;

  logic [AW-1:0] scan_j_q, scan_jd_q;
  logic          scan_v_q;
  logic [31:0]   m_q, c_q;
  logic [NW-1:0] q_q;
  logic [31:0]   k_q, km1_q, km2_q, p1_q, tri_q, p3_q;

  logic [32:0]   nn_i_q;
  logic [NW-1:0] nn_steps_q;
  logic [NW-1:0] n_q;

  logic          out_valid_q, out_kind_q, out_last_q;
  logic [31:0]   out_seq_q, out_lost_q;
  logic [63:0]   out_pay_q;
  logic [1:0]    out_status_q;

  logic          seq_we, seq_re;
  logic [AW-1:0] seq_wa, seq_ra;
  logic [31:0]   seq_wd;
  logic [31:0]   d_seq_wp, d_wp_rp, dist_a, dist_b;
  logic [31:0]   lim, kdiff, off;
  logic [63:0]   prod2;
  logic          out_busy, resync;

  assign resync   = far_q || full_q;
  assign out_busy = out_valid_q && !m_tready_i;

  // ring memory ports
  always_comb begin
    seq_we = 1'b0;
    seq_wa = clr_q;
    seq_wd = '0;
    if (cmd_i.clr_wr) begin
      seq_we = 1'b1;
      seq_wa = clr_q;
    end else if (cmd_i.arr_wr0) begin
      seq_we = 1'b1;
      seq_wa = write_ptr_q[AW-1:0];
    end else if (cmd_i.arr_wr1) begin
      seq_we = 1'b1;
      seq_wa = it_seq_q[AW-1:0];
      seq_wd = it_seq_q;
    end
    seq_re = cmd_i.sk_step || cmd_i.nn_rd || cmd_i.rd_slot;
    if (cmd_i.sk_step)    seq_ra = scan_j_q;
    else if (cmd_i.nn_rd) seq_ra = nn_i_q[AW-1:0];
    else                  seq_ra = read_ptr_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (seq_we) slot_seq_mem[seq_wa] <= seq_wd;
    if (seq_re) seq_rd_q <= slot_seq_mem[seq_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arr_wr1) slot_data_mem[it_seq_q[AW-1:0]] <= it_pay_q;
    if (cmd_i.rd_slot) data_rd_q <= slot_data_mem[read_ptr_q[AW-1:0]];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_diff_q <= srb_pkg::MAX_DIFF_RST;
      lost_to_q  <= srb_pkg::LOST_TO_RST;
      lock_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        srb_pkg::CFG_MAX_DIFF: max_diff_q <= cfg_data_i;
        srb_pkg::CFG_LOST_TO:  lost_to_q  <= cfg_data_i[15:0];
        srb_pkg::CFG_LOCK:     lock_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // item, distance, scan and multiply registers
  always_comb begin
    d_seq_wp = it_seq_q - write_ptr_q;
    d_wp_rp  = write_ptr_q - read_ptr_q;
    dist_a   = d_seq_wp[31] ? (32'd0 - d_seq_wp) : d_seq_wp;
    dist_b   = d_wp_rp[31] ? (32'd0 - d_wp_rp) : d_wp_rp;
    lim      = (m_q < write_ptr_q) ? m_q : write_ptr_q;
    kdiff    = (lim - read_ptr_q) >> AW;
    off      = {{(32-AW){1'b0}}, scan_jd_q - read_ptr_q[AW-1:0]};
    prod2    = {32'd0, km1_q} * {32'd0, km2_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      it_action_q <= in_action_i;
      it_seq_q    <= in_seq_i;
      it_ok_q     <= in_ok_i;
      it_pay_q    <= in_payload_i;
    end
    if (cmd_i.arr_dist) begin
      far_q  <= dist_a > max_diff_q;
      full_q <= dist_b >= 32'(RING_DEPTH - 2);
    end
    if (cmd_i.latch_tag) cur_tag_q <= seq_rd_q;
    if (cmd_i.sk_start) begin
      m_q <= srb_pkg::SEQ_MAX;
      c_q <= '0;
      q_q <= '0;
    end else if (scan_v_q && (seq_rd_q > read_ptr_q)) begin
      if (seq_rd_q < m_q) m_q <= seq_rd_q;
      c_q <= c_q + seq_rd_q - read_ptr_q - off;
      q_q <= q_q + 1'b1;
    end
    if (cmd_i.sk_step) scan_jd_q <= scan_j_q;
    if (cmd_i.sk_lim) begin
      k_q   <= kdiff;
      km1_q <= kdiff - 32'd1;
      km2_q <= kdiff - 32'd2;
    end
    if (cmd_i.sk_mul1) p1_q  <= km1_q * c_q;
    if (cmd_i.sk_mul2) tri_q <= prod2[32:1];
    if (cmd_i.sk_mul3) p3_q  <= {{(32-NW){1'b0}}, q_q} * tri_q;
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      scan_j_q   <= '0;
      scan_v_q   <= 1'b0;
      nn_i_q     <= '0;
      nn_steps_q <= '0;
      n_q        <= '0;
    end else begin
      scan_v_q <= cmd_i.sk_step;
      if (cmd_i.clr_wr)   clr_q <= clr_q + 1'b1;
      if (cmd_i.sk_start) scan_j_q <= '0;
      else if (cmd_i.sk_step) scan_j_q <= scan_j_q + 1'b1;
      if (cmd_i.gap_start) begin
        nn_i_q     <= {1'b0, read_ptr_q} + 33'd1;
        nn_steps_q <= '0;
      end else if (cmd_i.nn_adv) begin
        nn_i_q     <= nn_i_q + 33'd1;
        nn_steps_q <= nn_steps_q + 1'b1;
      end
      if (cmd_i.load_item)     n_q <= '0;
      else if (cmd_i.emit_pkt) n_q <= n_q + 1'b1;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_ptr_q  <= 32'd0;
      write_ptr_q <= 32'd1;
      lost_q      <= 32'd0;
      gap_q       <= 16'd0;
    end else begin
      if (cmd_i.force_upd) read_ptr_q <= write_ptr_q - 32'd1;
      if (cmd_i.tick && (gap_q != srb_pkg::GAP_MAX)) gap_q <= gap_q + 16'd1;
      if (cmd_i.arr_wr0 && resync) begin
        lost_q <= (it_seq_q > write_ptr_q) ? (it_seq_q - write_ptr_q - 32'd1)
                                           : (lost_q + 32'd1);
      end
      if (cmd_i.arr_wr1) begin
        if (resync) begin
          read_ptr_q  <= it_seq_q;
          write_ptr_q <= it_seq_q + 32'd1;
        end else begin
          if (it_seq_q >= write_ptr_q) write_ptr_q <= it_seq_q + 32'd1;
          if (read_ptr_q == 32'd0)     read_ptr_q  <= it_seq_q;
        end
      end
      if (cmd_i.deliver) begin
        gap_q      <= 16'd0;
        read_ptr_q <= read_ptr_q + 32'd1;
      end
      if (cmd_i.sk_apply) begin
        lost_q     <= lost_q + p1_q - (p3_q << AW);
        read_ptr_q <= read_ptr_q + (km1_q << AW);
      end
      if (cmd_i.gap_start) begin
        lost_q <= lost_q + ((cur_tag_q > read_ptr_q) ? (cur_tag_q - read_ptr_q) : 32'd1);
      end
      if (cmd_i.nn_take) read_ptr_q <= nn_i_q[31:0];
      if (cmd_i.nn_end)  read_ptr_q <= write_ptr_q;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pkt || cmd_i.emit_close) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pkt) begin
      out_kind_q   <= 1'b0;
      out_seq_q    <= seq_rd_q;
      out_pay_q    <= data_rd_q;
      out_status_q <= srb_pkg::ST_OK;
      out_lost_q   <= lost_q;
      out_last_q   <= 1'b0;
    end else if (cmd_i.emit_close) begin
      out_kind_q   <= 1'b1;
      out_seq_q    <= '0;
      out_pay_q    <= '0;
      out_status_q <= cmd_i.close_status;
      out_lost_q   <= lost_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_seq_o     = out_seq_q;
  assign out_payload_o = out_pay_q;
  assign out_status_o  = out_status_q;
  assign out_lost_o    = out_lost_q;
  assign out_last_o    = out_last_q;

  always_comb begin
    sts_o             = '0;
    sts_o.clear_last  = (clr_q == AW'(RING_DEPTH - 1));
    sts_o.action      = srb_pkg::action_e'(it_action_q);
    sts_o.packet_ok   = it_ok_q;
    sts_o.empty_start = (write_ptr_q == 32'd1) && (read_ptr_q == 32'd0);
    sts_o.rp_lt_wp    = read_ptr_q < write_ptr_q;
    sts_o.tag_match   = seq_rd_q == read_ptr_q;
    sts_o.tag_gt      = seq_rd_q > read_ptr_q;
    sts_o.expired     = !({16'd0, gap_q} < {16'd0, lost_to_q});
    sts_o.skip_ok     = k_q >= 32'd2;
    sts_o.resync      = resync;
    sts_o.nn_more     = (nn_i_q < {1'b0, write_ptr_q}) && (nn_steps_q < NW'(RING_DEPTH));
    sts_o.nn_hit      = seq_rd_q > read_ptr_q;
    sts_o.emit_ok     = !lock_q && (n_q < NW'(RING_DEPTH));
    sts_o.out_busy    = out_busy;
    sts_o.scan_last   = scan_j_q == AW'(RING_DEPTH - 1);
  end

  a_deliver_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deliver |-> seq_rd_q == read_ptr_q)
    else $error("delivery of a slot whose tag does not match read pointer");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_pkt || cmd_i.emit_close) |-> !out_busy)
    else $error("output word overwritten while stalled");

  a_close_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_close |=> out_valid_q && out_last_q && out_kind_q)
    else $error("closing word not presented");

endmodule

// File: design/sequence_reorder_buffer.sv
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: action; tdata: seq_num, packet_ok, payload
// m_axis    out  tvalid/tready/tlast    tuser: kind; tdata: out_seq, out_payload, status,
//                                       lost_total
// cfg       in   cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// one item at a time; tick, force, a rejected packet and a drain on an empty start go straight
// to the closing word, a packet measures its distances and writes its ring slot, and a drain
// checks the slots in turn, delivers a word, releases a slot without one, skips the ring or
// searches for a newer slot.
// after reset a clearing pass zeroes the tags, s_axis_tready_o low.
// the result word is held in an output register; a stall holds the sequencer
// only when a further word is due.
module sequence_reorder_buffer #(
  parameter int unsigned RING_DEPTH = srb_pkg::RING_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [103:0]                  s_axis_tdata_i,  // seq_num, packet_ok, payload
  input  logic [1:0]                    s_axis_tuser_i,  // action
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [135:0]                  m_axis_tdata_o,  // out_seq, out_payload, status,
                                                         // lost_total
  output logic [0:0]                    m_axis_tuser_o,  // kind
  output logic                          m_axis_tlast_o
);

  srb_pkg::cmd_t cmd;
  srb_pkg::sts_t sts;

  logic        out_kind;
  logic [31:0] out_seq, out_lost;
  logic [63:0] out_pay;
  logic [1:0]  out_status;

  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srb_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_action_i   (s_axis_tuser_i),
    .in_seq_i      (s_axis_tdata_i[31:0]),
    .in_ok_i       (s_axis_tdata_i[32]),
    .in_payload_i  (s_axis_tdata_i[96:33]),
    .m_tready_i    (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_kind_o    (out_kind),
    .out_seq_o     (out_seq),
    .out_payload_o (out_pay),
    .out_status_o  (out_status),
    .out_lost_o    (out_lost),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, out_lost, out_status, out_pay, out_seq};
  assign m_axis_tuser_o = out_kind;

endmodule
